### rtl/core/psse_pkg.sv
// ----------------------------------------------------------------------------
// Per-user stack engine package
// Shared widths, operation codes and control types for the stack engine.
// ----------------------------------------------------------------------------
package psse_pkg;

  localparam int OP_W     = 3;
  localparam int USER_W   = 4;
  localparam int ID_W     = 32;
  localparam int DEPTH_OUT_W = 5;

  localparam int USERS_DEF = 16;
  localparam int DEPTH_DEF = 16;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  // Identifier returned by a pop or peek of an empty stack.
  localparam logic [ID_W-1:0] EMPTY_ID = '1;

  // Control of the fill count memory.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } fill_ctl_t;

endpackage

### rtl/core/psse_fill_mem.sv
// ----------------------------------------------------------------------------
// Fill count memory
// One fill count per user in a synchronous memory, with a valid bit per
// user so that a clear of all stacks only resets the valid bits.
// ----------------------------------------------------------------------------
module psse_fill_mem import psse_pkg::*; #(
  parameter int USERS = USERS_DEF,
  parameter int UW    = 4,
  parameter int FW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fill_ctl_t     ctl_i,
  input  logic [UW-1:0] rd_addr_i,
  input  logic [UW-1:0] wr_addr_i,
  input  logic [FW-1:0] wr_data_i,
  output logic [FW-1:0] rd_data_o
);

  logic [FW-1:0]    mem [USERS];
  logic [USERS-1:0] vld_q;
  logic [FW-1:0]    rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // A count that was never written since the last clear reads as zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### rtl/core/psse_store_ram.sv
// ----------------------------------------------------------------------------
// Stack entry memory
// Single-port synchronous memory holding the stack entries of all users.
// ----------------------------------------------------------------------------
module psse_store_ram import psse_pkg::*; #(
  parameter int WORDS = USERS_DEF * DEPTH_DEF,
  parameter int AW    = 8
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   addr_i,
  input  logic [ID_W-1:0] wr_data_i,
  output logic [ID_W-1:0] rd_data_o
);

  logic [ID_W-1:0] mem [WORDS];
  logic [ID_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/per_user_stack_engine_top.sv
// ----------------------------------------------------------------------------
// Per-user stack engine
// One LIFO stack of 32-bit identifiers per user with push, pop, peek,
// size query and clear of all stacks.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low, and every item
// gives exactly one result, shown for a single cycle with result_valid_o
// high; the receiver cannot stall, so results must be captured on that
// cycle. Push, query, clear and a pop or peek of an empty stack pass only
// through the fill count read state; a pop or peek of a non-empty stack
// then also passes through the entry read state, since the fill count read
// and then the entry read each go through a synchronous memory. The result
// is registered out of the last of these states.
// ----------------------------------------------------------------------------
module per_user_stack_engine_top import psse_pkg::*; #(
  parameter int USERS = USERS_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [OP_W-1:0]        op_i,
  input  logic [USER_W-1:0]      user_i,
  input  logic [ID_W-1:0]        item_id_i,
  output logic                   result_valid_o,
  output logic [ID_W-1:0]        result_id_o,
  output logic                   is_empty_o,
  output logic [DEPTH_OUT_W-1:0] depth_now_o,
  output logic                   overflowed_o
);

  localparam int UW    = $clog2(USERS);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int WORDS = USERS * DEPTH;
  localparam int AW    = $clog2(WORDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [USER_W-1:0] user_q;
  logic [ID_W-1:0]   id_q;
  logic [FW-1:0]     fill_new_q, fill_new_d;

  logic                   res_vld_q, res_vld_d;
  logic [ID_W-1:0]        res_id_q, res_id_d;
  logic                   res_empty_q, res_empty_d;
  logic [FW-1:0]          res_fill_q, res_fill_d;
  logic                   res_ovf_q, res_ovf_d;

  fill_ctl_t     fill_ctl;
  logic [FW-1:0] fill_rd;
  logic [FW-1:0] fill_wr_data;
  logic [UW-1:0] uidx;
  logic          uvalid;
  logic [FW-1:0] fill_cur;
  logic          empty;
  logic [AW-1:0] base;
  logic [AW-1:0] st_addr;
  logic          st_wr, st_rd;
  logic [ID_W-1:0] st_rd_data;
  logic          accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  assign uidx     = UW'(user_q);
  assign uvalid   = (32'(user_q) < USERS);
  assign fill_cur = uvalid ? fill_rd : '0;
  assign empty    = (fill_cur == '0);
  assign base     = AW'(32'(uidx) * 32'(DEPTH));

  psse_fill_mem #(
    .USERS (USERS),
    .UW    (UW),
    .FW    (FW)
  ) u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (fill_ctl),
    .rd_addr_i (UW'(user_i)),
    .wr_addr_i (uidx),
    .wr_data_i (fill_wr_data),
    .rd_data_o (fill_rd)
  );

  psse_store_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr),
    .rd_en_i   (st_rd),
    .addr_i    (st_addr),
    .wr_data_i (id_q),
    .rd_data_o (st_rd_data)
  );

  always_comb begin
    state_d      = state_q;
    fill_new_d   = fill_new_q;
    res_vld_d    = 1'b0;
    res_id_d     = res_id_q;
    res_empty_d  = res_empty_q;
    res_fill_d   = res_fill_q;
    res_ovf_d    = res_ovf_q;
    fill_ctl     = '0;
    fill_ctl.rd  = accept;
    fill_wr_data = '0;
    st_wr        = 1'b0;
    st_rd        = 1'b0;
    st_addr      = base + AW'(fill_cur);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d     = ST_IDLE;
        res_vld_d   = 1'b1;
        res_id_d    = '0;
        res_empty_d = empty;
        res_fill_d  = fill_cur;
        res_ovf_d   = 1'b0;
        case (op_q)
          OP_PUSH: begin
            if (!uvalid || (fill_cur >= FW'(DEPTH))) begin
              res_ovf_d = 1'b1;
            end else begin
              st_wr        = 1'b1;
              fill_ctl.wr  = 1'b1;
              fill_wr_data = fill_cur + FW'(1);
              res_fill_d   = fill_cur + FW'(1);
            end
          end
          OP_POP, OP_PEEK: begin
            if (empty) begin
              res_id_d = EMPTY_ID;
            end else begin
              // The entry read goes through the synchronous store; the result waits for it.
              res_vld_d = 1'b0;
              state_d   = ST_READ;
              st_rd     = 1'b1;
              st_addr   = base + AW'(fill_cur - FW'(1));
              if (op_q == OP_POP) begin
                fill_ctl.wr  = 1'b1;
                fill_wr_data = fill_cur - FW'(1);
                fill_new_d   = fill_cur - FW'(1);
              end else begin
                fill_new_d   = fill_cur;
              end
            end
          end
          OP_CLEAR: begin
            fill_ctl.clr = 1'b1;
            res_fill_d   = '0;
          end
          OP_QUERY: begin
            res_fill_d = fill_cur;
          end
          default: begin
            res_fill_d = fill_cur;
          end
        endcase
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        res_vld_d   = 1'b1;
        res_id_d    = st_rd_data;
        res_empty_d = 1'b0;
        res_fill_d  = fill_new_q;
        res_ovf_d   = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      user_q <= user_i;
      id_q   <= item_id_i;
    end
    fill_new_q  <= fill_new_d;
    res_id_q    <= res_id_d;
    res_empty_q <= res_empty_d;
    res_fill_q  <= res_fill_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_id_o    = res_id_q;
  assign is_empty_o     = res_empty_q;
  assign depth_now_o    = DEPTH_OUT_W'(res_fill_q);
  assign overflowed_o   = res_ovf_q;

endmodule

### sim/tb_per_user_stack_engine_top.sv
// ----------------------------------------------------------------------------
// Testbench for the per-user stack engine
// Sends push, pop, peek, query, clear and unused operation codes, first as
// short directed sequences and then as random traffic that fills, overflows
// and drains the stacks. A predictor tracks every stack, and each result
// strobe is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_per_user_stack_engine_top;
  import psse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int USERS = USERS_DEF;
  localparam int DEPTH = DEPTH_DEF;

  // Operation codes the block does not define; it treats them as a query.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [ID_W-1:0]        result_id;
    logic                   is_empty;
    logic [DEPTH_OUT_W-1:0] depth_now;
    logic                   overflowed;
  } stack_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [OP_W-1:0]        op_i;
  logic [USER_W-1:0]      user_i;
  logic [ID_W-1:0]        item_id_i;
  logic                   result_valid_o;
  logic [ID_W-1:0]        result_id_o;
  logic                   is_empty_o;
  logic [DEPTH_OUT_W-1:0] depth_now_o;
  logic                   overflowed_o;

  // Predicted stack contents and fill counts.
  logic [ID_W-1:0] model_store [USERS][DEPTH];
  int unsigned     model_fill  [USERS];

  stack_result_t pending_results[$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned push_count;
  int unsigned dropped_push_count;
  int unsigned read_count;
  int unsigned empty_read_count;
  int unsigned clear_count;
  int unsigned burst_left;

  per_user_stack_engine_top #(
    .USERS(USERS),
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .user_i        (user_i),
    .item_id_i     (item_id_i),
    .result_valid_o(result_valid_o),
    .result_id_o   (result_id_o),
    .is_empty_o    (is_empty_o),
    .depth_now_o   (depth_now_o),
    .overflowed_o  (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("[per_user_stack_engine_top] ERROR");
    $finish;
  end

  // Applies one operation to the predicted stacks and returns its result.
  function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0]   op,
                                                   input logic [USER_W-1:0] user,
                                                   input logic [ID_W-1:0]   id);
    stack_result_t res;
    int unsigned   fill;
    bit            present;
    present = (int'(user) < USERS);
    fill    = present ? model_fill[user] : 0;
    res.result_id  = '0;
    res.is_empty   = (fill == 0);
    res.depth_now  = DEPTH_OUT_W'(fill);
    res.overflowed = 1'b0;
    case (op)
      OP_PUSH: begin
        push_count++;
        if (!present || fill >= DEPTH) begin
          res.overflowed = 1'b1;
          dropped_push_count++;
        end else begin
          model_store[user][fill] = id;
          model_fill[user]        = fill + 1;
          res.depth_now           = DEPTH_OUT_W'(fill + 1);
        end
      end
      OP_POP, OP_PEEK: begin
        read_count++;
        if (fill == 0) begin
          res.result_id = EMPTY_ID;
          res.depth_now = '0;
          empty_read_count++;
        end else begin
          res.result_id = model_store[user][fill-1];
          if (op == OP_POP) begin
            model_fill[user] = fill - 1;
            res.depth_now    = DEPTH_OUT_W'(fill - 1);
          end
        end
      end
      OP_CLEAR: begin
        clear_count++;
        foreach (model_fill[u]) model_fill[u] = 0;
        res.depth_now = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item waiting, expected none, actual id %h",
                 $time, result_id_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_id_o !== want.result_id)
          report_mismatch("result_id", want.result_id, result_id_o);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", ID_W'(want.is_empty), ID_W'(is_empty_o));
        if (depth_now_o !== want.depth_now)
          report_mismatch("depth_now", ID_W'(want.depth_now), ID_W'(depth_now_o));
        if (overflowed_o !== want.overflowed)
          report_mismatch("overflowed", ID_W'(want.overflowed), ID_W'(overflowed_o));
      end
    end
  end

  // Holds one item on the inputs until the block takes it. start_i is left
  // high so that a following item can go out back to back.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [USER_W-1:0] user,
                           input logic [ID_W-1:0] id);
    start_i   <= 1'b1;
    op_i      <= op;
    user_i    <= user;
    item_id_i <= id;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(apply_stack_op(op, user, id));
    items_sent++;
  endtask

  // Sender bursts: after a burst of random length, a random gap.
  task automatic idle_between_items();
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = $urandom_range(24, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_stacks();
    send_item(OP_POP,     4'd0,  32'h1234_5678);
    send_item(OP_PEEK,    4'd15, 32'hFFFF_FFFF);
    send_item(OP_QUERY,   4'd7,  32'h0000_0000);
    send_item(OP_SPARE_5, 4'd0,  32'hAAAA_AAAA);
    send_item(OP_SPARE_6, 4'd10, 32'h5555_5555);
    send_item(OP_SPARE_7, 4'd5,  32'h0F0F_0F0F);
    wait_for_results();
  endtask

  task automatic test_fill_and_overflow();
    logic [ID_W-1:0] id;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       id = 32'h8000_0000;
        1:       id = 32'h7FFF_FFFF;
        2:       id = 32'hFFFF_FFFF;
        3:       id = 32'h0000_0000;
        default: id = $urandom();
      endcase
      send_item(OP_PUSH, 4'd15, id);
    end
    // The stack is full now, so this identifier must be dropped.
    send_item(OP_PUSH,  4'd15, 32'hDEAD_BEEF);
    send_item(OP_QUERY, 4'd15, 32'h0);
    send_item(OP_PEEK,  4'd15, 32'h0);
    send_item(OP_POP,   4'd15, 32'h0);
    wait_for_results();
  endtask

  task automatic test_clear_all();
    send_item(OP_CLEAR, 4'd15, 32'h0);
    send_item(OP_CLEAR, 4'd3,  32'h0);
    send_item(OP_POP,   4'd15, 32'h0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned push_pct,
                                     input bit with_gaps);
    logic [OP_W-1:0]   op;
    logic [USER_W-1:0] user;
    logic [ID_W-1:0]   id;
    int unsigned       pick;
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < push_pct) begin
        op = OP_PUSH;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      op = OP_POP;
        else if (pick < 75) op = OP_PEEK;
        else if (pick < 88) op = OP_QUERY;
        else if (pick < 97) op = OP_SPARE_5 + OP_W'($urandom_range(2));
        else                op = OP_CLEAR;
      end
      // A few hot users so that stacks reach full and empty often.
      if ($urandom_range(3) != 0) user = USER_W'($urandom_range(2));
      else                        user = USER_W'($urandom_range(USERS - 1));
      case ($urandom_range(15))
        0:       id = 32'h8000_0000;
        1:       id = 32'h7FFF_FFFF;
        2:       id = 32'hFFFF_FFFF;
        3:       id = 32'h0000_0000;
        default: id = $urandom();
      endcase
      send_item(op, user, id);
      if (with_gaps) idle_between_items();
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    op_i      <= OP_QUERY;
    user_i    <= '0;
    item_id_i <= '0;
    error_count        = 0;
    items_sent         = 0;
    push_count         = 0;
    dropped_push_count = 0;
    read_count         = 0;
    empty_read_count   = 0;
    clear_count        = 0;
    burst_left         = 0;
    foreach (model_fill[u]) model_fill[u] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_stacks();
    test_fill_and_overflow();
    test_clear_all();

    test_random_traffic(400, 75, 1'b1);
    test_random_traffic(400, 25, 1'b1);
    test_random_traffic(400, 50, 1'b0);
    test_random_traffic(300, 50, 1'b1);

    start_i <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived, expected 0, actual %0d",
               $time, pending_results.size(), pending_results.size());
      error_count++;
    end

    $display("Covered %0d items: %0d pushes with %0d dropped on a full stack,",
             items_sent, push_count, dropped_push_count);
    $display("%0d pops and peeks with %0d on an empty stack, and %0d clears.",
             read_count, empty_read_count, clear_count);
    if (error_count == 0) begin
      $display("[per_user_stack_engine_top] OK");
    end else begin
      $display("[per_user_stack_engine_top] ERROR");
    end
    $finish;
  end

endmodule
